// ----- rtl/tlwi_pkg.sv -----
// ----------------------------------------------------------------------------
// tlwi_pkg
// Shared constants and types for the text line wrap indexer: control
// codes, table limits, the scan state record and the result record.
// ----------------------------------------------------------------------------
package tlwi_pkg;

    // Field widths
    localparam int BYTE_W  = 8;
    localparam int COL_W   = 8;
    localparam int LINE_W  = 11;
    localparam int OFS_W   = 32;

    // Wrap limits
    localparam int MAX_LINES = 1024;
    localparam int TAB_STOP  = 8;
    localparam int COLS_RST  = 80;

    // Character codes
    localparam logic [BYTE_W-1:0] CHR_TAB = 8'h09;
    localparam logic [BYTE_W-1:0] CHR_LF  = 8'h0A;
    localparam logic [BYTE_W-1:0] CHR_CR  = 8'h0D;

    // Scan state carried from one byte to the next
    typedef struct packed {
        logic [COL_W-1:0]  col;
        logic [LINE_W-1:0] line_cnt;
        logic [OFS_W-1:0]  byte_pos;
        logic              lead_pend;
        logic [OFS_W-1:0]  lead_off;
        logic              limit;
    } t_state;

    // One result beat
    typedef struct packed {
        logic              start_valid;
        logic [OFS_W-1:0]  line_start_offset;
        logic [LINE_W-1:0] line_number;
        logic [LINE_W-1:0] lines_so_far;
        logic              table_full;
    } t_result;

endpackage

// ----- rtl/tlwi_core.sv -----
// ----------------------------------------------------------------------------
// tlwi_core
// Next-state and result logic for one text byte: column advance, tab
// stops, double-width placement, line end detection and line table limit.
// ----------------------------------------------------------------------------
module tlwi_core import tlwi_pkg::*; (
    input  t_state            i_state,
    input  logic [BYTE_W-1:0] i_text_byte,
    input  logic              i_last_byte,
    input  logic [COL_W-1:0]  i_column_count,
    output t_state            o_state,
    output t_result           o_result
);

    logic [COL_W:0]    col_ext;
    logic [COL_W:0]    cols_ext;
    logic [COL_W:0]    wide_col;
    logic [COL_W:0]    tab_sum;
    logic [COL_W:0]    narrow_col;
    logic [OFS_W-1:0]  next_pos;
    logic [OFS_W-1:0]  wide_off;
    logic [LINE_W-1:0] line_inc;
    logic              line_lim;
    logic              do_end;
    logic              has_next;
    logic [OFS_W-1:0]  end_off;
    logic              do_wide;
    t_state            nxt;

    // Column arithmetic kept one bit wider: a tab near the right edge can reach 256
    assign col_ext    = {1'b0, i_state.col};
    assign cols_ext   = {1'b0, i_column_count};
    assign wide_col   = col_ext + (COL_W+1)'(2);
    assign tab_sum    = col_ext + (COL_W+1)'(TAB_STOP);
    assign narrow_col = (i_text_byte == CHR_TAB)
                      ? tab_sum - (tab_sum % (COL_W+1)'(TAB_STOP))
                      : col_ext + (COL_W+1)'(1);
    assign next_pos   = i_state.byte_pos + OFS_W'(1);
    // A held lead uses its stored offset; a lead on the final byte uses its own
    assign wide_off   = i_state.lead_pend ? i_state.lead_off : i_state.byte_pos;
    assign line_inc   = i_state.line_cnt + LINE_W'(1);
    assign line_lim   = (line_inc >= LINE_W'(MAX_LINES));

    // Classify the byte and decide whether it closes the current line
    always_comb begin
        nxt          = i_state;
        nxt.byte_pos = next_pos;
        do_end       = 1'b0;
        has_next     = 1'b0;
        end_off      = next_pos;
        do_wide      = 1'b0;

        if (!i_state.limit) begin
            if (i_state.lead_pend) begin
                nxt.lead_pend = 1'b0;
                do_wide       = 1'b1;
            end else if (i_text_byte == CHR_CR) begin
                nxt.col = i_state.col;
            end else if (i_text_byte[BYTE_W-1]) begin
                nxt.lead_off = i_state.byte_pos;
                if (i_last_byte) begin
                    do_wide = 1'b1;
                end else begin
                    nxt.lead_pend = 1'b1;
                end
            end else begin
                if (narrow_col >= cols_ext || i_text_byte == CHR_LF) begin
                    do_end   = 1'b1;
                    has_next = !i_last_byte;
                    nxt.col  = '0;
                end else begin
                    nxt.col = narrow_col[COL_W-1:0];
                end
            end

            // Place a double-width character; on overflow it opens the next line
            if (do_wide) begin
                if (wide_col >= cols_ext) begin
                    do_end   = 1'b1;
                    has_next = 1'b1;
                    end_off  = wide_off;
                    nxt.col  = COL_W'(2);
                end else begin
                    nxt.col = wide_col[COL_W-1:0];
                end
            end
        end

        if (do_end) begin
            nxt.line_cnt = line_inc;
            if (line_lim) begin
                nxt.limit = 1'b1;
            end
        end
    end

    // Build the result beat from the updated counters
    always_comb begin
        o_result                   = '0;
        if (do_end && has_next && !line_lim) begin
            o_result.start_valid       = 1'b1;
            o_result.line_start_offset = end_off;
            o_result.line_number       = line_inc;
        end
        o_result.lines_so_far = nxt.line_cnt;
        o_result.table_full   = nxt.limit;
    end

    // Drop all scan state after the final byte of a file
    assign o_state = i_last_byte ? t_state'('0) : nxt;

endmodule

// ----- rtl/text_line_wrap_indexer.sv -----
// ----------------------------------------------------------------------------
// text_line_wrap_indexer
// Scans a text file one byte per beat and reports the byte offset at which
// each wrapped display line begins, under a programmable column count.
//
//   channel   direction  handshake             payload
//   input     in         i_valid / o_ready     i_text_byte, i_last_byte
//   result    out        o_valid / i_ready     o_start_valid, o_line_start_offset,
//                                              o_line_number, o_lines_so_far,
//                                              o_table_full
//   config    in         i_cfg_we              i_cfg_data (column count)
//
// One byte per cycle sustained; each byte gives exactly one result beat in the
// cycle after it is accepted. The scan state and the result register update
// in the same cycle, so throughput is set by the single output register.
// o_ready is high whenever the result register is empty or being drained,
// so a stalled output holds one beat and back-pressures the input.
// Synchronous active-low reset clears the scan state and sets 80 columns.
// ----------------------------------------------------------------------------
module text_line_wrap_indexer import tlwi_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    // Configuration
    input  logic              i_cfg_we,
    input  logic [COL_W-1:0]  i_cfg_data,
    // Input bytes
    input  logic              i_valid,
    output logic              o_ready,
    input  logic [BYTE_W-1:0] i_text_byte,
    input  logic              i_last_byte,
    // Results
    output logic              o_valid,
    input  logic              i_ready,
    output logic              o_start_valid,
    output logic [OFS_W-1:0]  o_line_start_offset,
    output logic [LINE_W-1:0] o_line_number,
    output logic [LINE_W-1:0] o_lines_so_far,
    output logic              o_table_full
);

    logic [COL_W-1:0] r_cols;
    t_state           r_state;
    t_state           n_state;
    t_result          n_result;
    t_result          r_result;
    logic             r_out_valid;
    logic             in_fire;

    assign o_ready = !r_out_valid || i_ready;
    assign in_fire = i_valid && o_ready;

    tlwi_core u_core (
        .i_state        (r_state),
        .i_text_byte    (i_text_byte),
        .i_last_byte    (i_last_byte),
        .i_column_count (r_cols),
        .o_state        (n_state),
        .o_result       (n_result)
    );

    // Hold the column count register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cols <= COL_W'(COLS_RST);
        end else if (i_cfg_we) begin
            r_cols <= i_cfg_data;
        end
    end

    // Advance the scan state on every accepted beat
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= '0;
        end else if (in_fire) begin
            r_state <= n_state;
        end
    end

    // Track result register occupancy
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (o_ready) begin
            r_out_valid <= i_valid;
        end
    end

    // Load the result payload
    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_result <= n_result;
        end
    end

    assign o_valid             = r_out_valid;
    assign o_start_valid       = r_result.start_valid;
    assign o_line_start_offset = r_result.line_start_offset;
    assign o_line_number       = r_result.line_number;
    assign o_lines_so_far      = r_result.lines_so_far;
    assign o_table_full        = r_result.table_full;

    // A reported line start is never past the table limit
    a_start_not_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !(o_start_valid && o_table_full))
        else $error("line start reported with table full");

    // A reported line number equals the running line count of the same beat
    a_number_matches_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_start_valid) |-> (o_line_number == o_lines_so_far))
        else $error("line number differs from line count");

    // The line count never passes the table size
    a_count_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_lines_so_far <= LINE_W'(MAX_LINES)))
        else $error("line count beyond table size");

    // An accepted byte always yields a result beat in the next cycle
    a_byte_gives_beat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && o_ready) |=> o_valid)
        else $error("accepted byte produced no result");

endmodule
